@@ rtl/sorted_priority_queue_assert.svh @@
// Assertion macros for the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int ID_W   = 16;
   localparam int KEY_W  = 10;
   localparam int DAYS_W = 13;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_INSERTED = 2'd0,
      STAT_REMOVED  = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Logical indexes: 0 is the head of the queue.
   typedef struct packed {
      logic [PTR_W-1:0] rd_idx;
      logic             wr_en;
      logic [PTR_W-1:0] wr_idx;
      entry_type        wr_data;
      logic             pop;
   } store_ctl_type;

endpackage

@@ rtl/spq_if.sv @@
interface spq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [spq_pkg::ID_W-1:0]   item_id;
   logic [spq_pkg::KEY_W-1:0]  priority_key;

   modport source (output valid, command, item_id, priority_key, input ready);
   modport sink   (input valid, command, item_id, priority_key, output ready);
endinterface

interface spq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [spq_pkg::STAT_W-1:0]  status;
   logic [spq_pkg::ID_W-1:0]    removed_id;
   logic [spq_pkg::KEY_W-1:0]   removed_key;
   logic [spq_pkg::DAYS_W-1:0]  derived_days;
   logic [spq_pkg::OCC_W-1:0]   occupancy;

   modport source (output valid, status, removed_id, removed_key, derived_days, occupancy,
                   input ready);
   modport sink   (input valid, status, removed_id, removed_key, derived_days, occupancy,
                   output ready);
endinterface

@@ rtl/spq_store.sv @@
// Ring buffer of entries: logical index is relative to a head pointer, so a
// pop only advances the pointer. One write and one registered read per cycle.
module spq_store (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::store_ctl_type ctl,
   output spq_pkg::entry_type     rd_data
);
   import spq_pkg::*;

   entry_type        mem [CAPACITY];
   entry_type        rd_data_ff;
   logic [PTR_W-1:0] base_ff;
   logic [PTR_W-1:0] base_in;

   function automatic logic [PTR_W-1:0] phys(logic [PTR_W-1:0] b, logic [PTR_W-1:0] idx);
      logic [PTR_W:0] sum;
      sum = {1'b0, b} + {1'b0, idx};
      if (sum >= (PTR_W+1)'(CAPACITY)) begin
         sum = sum - (PTR_W+1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

   always_comb begin
      base_in = base_ff;
      if (ctl.pop) begin
         base_in = phys(base_ff, PTR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[phys(base_ff, ctl.wr_idx)] <= ctl.wr_data;
      end
      rd_data_ff <= mem[phys(base_ff, ctl.rd_idx)];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Bounded priority queue of up to CAPACITY entries held in descending key order
// in a ring buffer with one write and one registered read port, and one key
// comparator stepping through it. Each request gives one response with the
// status and the occupancy after it. A remove on empty, an insert on full and an
// insert into an empty queue go straight to the response step; a remove reads
// the head, then advances the pointer; any other insert moves entries toward the
// tail until its place is found. The insert walks from the tail one entry a
// cycle, comparing and moving it while the read port fetches the next one. A
// response that has not been taken holds the block in its last step, and so
// holds off the next request, until the response beat goes out. A new request
// is taken only in the idle state.
module sorted_priority_queue (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_PLACE  = 5'b00100,
      ST_POP    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [KEY_W-1:0]  key_ff, key_in;

   status_type        res_stat_ff, res_stat_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [DAYS_W-1:0] res_days_ff, res_days_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [DAYS_W-1:0] rsp_days_ff, rsp_days_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   store_ctl_type     ctl;
   entry_type         rd;
   logic              accept;
   logic              rsp_free;
   logic              key_lt;
   logic              key_eq;
   logic              go_down;

   spq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (rd)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // Key comparator for the scan. Head is displaced only by a strictly larger key.
   assign key_lt  = rd.key < key_ff;
   assign key_eq  = rd.key == key_ff;
   assign go_down = key_lt || (key_eq && (idx_ff != '0));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      key_in       = key_ff;
      res_stat_in  = res_stat_ff;
      res_id_in    = res_id_ff;
      res_key_in   = res_key_ff;
      res_days_in  = res_days_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_days_in  = rsp_days_ff;
      rsp_occ_in   = rsp_occ_ff;
      ctl.rd_idx   = '0;
      ctl.wr_en    = 1'b0;
      ctl.wr_idx   = '0;
      ctl.wr_data  = '{id: id_ff, key: key_ff};
      ctl.pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in       = req.item_id;
               key_in      = req.priority_key;
               res_id_in   = '0;
               res_key_in  = '0;
               res_days_in = '0;
               if (req.command == CMD_REMOVE) begin
                  if (cnt_ff == '0) begin
                     res_stat_in = STAT_EMPTY;
                     state_in    = ST_FINISH;
                  end else begin
                     ctl.rd_idx  = '0;
                     res_stat_in = STAT_REMOVED;
                     state_in    = ST_POP;
                  end
               end else begin
                  if (cnt_ff == CNT_W'(CAPACITY)) begin
                     res_stat_in = STAT_FULL;
                     state_in    = ST_FINISH;
                  end else if (cnt_ff == '0) begin
                     ctl.wr_en   = 1'b1;
                     ctl.wr_idx  = '0;
                     ctl.wr_data = '{id: req.item_id, key: req.priority_key};
                     cnt_in      = cnt_ff + CNT_W'(1);
                     res_stat_in = STAT_INSERTED;
                     state_in    = ST_FINISH;
                  end else begin
                     // start at the tail entry
                     idx_in      = PTR_W'(cnt_ff - CNT_W'(1));
                     ctl.rd_idx  = PTR_W'(cnt_ff - CNT_W'(1));
                     cnt_in      = cnt_ff + CNT_W'(1);
                     res_stat_in = STAT_INSERTED;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_idx = idx_ff + PTR_W'(1);
            if (go_down) begin
               ctl.wr_data = rd;
               if (idx_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  idx_in     = idx_ff - PTR_W'(1);
                  ctl.rd_idx = idx_ff - PTR_W'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PLACE: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_idx = '0;
            state_in   = ST_FINISH;
         end
         ST_POP: begin
            res_id_in   = rd.id;
            res_key_in  = rd.key;
            res_days_in = DAYS_W'({rd.key, 2'b00}) + DAYS_W'(rd.key);
            ctl.pop     = 1'b1;
            cnt_in      = cnt_ff - CNT_W'(1);
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_id_in    = res_id_ff;
               rsp_key_in   = res_key_ff;
               rsp_days_in  = res_days_ff;
               rsp_occ_in   = OCC_W'(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      res_stat_ff <= res_stat_in;
      res_id_ff   <= res_id_in;
      res_key_ff  <= res_key_in;
      res_days_ff <= res_days_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_days_ff <= rsp_days_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_stat_ff;
   assign rsp.removed_id   = rsp_id_ff;
   assign rsp.removed_key  = rsp_key_ff;
   assign rsp.derived_days = rsp_days_ff;
   assign rsp.occupancy    = rsp_occ_ff;

`include "sorted_priority_queue_assert.svh"

   `SPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(CAPACITY),
      "entry count over capacity")
   `SPQ_ASSERT_NOW(a_scan_in_range, state_ff == ST_SCAN, CNT_W'(idx_ff) < cnt_ff,
      "scan index past tail")
   `SPQ_ASSERT_NEXT(a_empty_pop_keeps,
      accept && (req.command == CMD_REMOVE) && (cnt_ff == '0),
      (cnt_ff == '0) && (state_ff == ST_FINISH), "remove on empty changed count")

endmodule
